// ----- hdl/rep_pkg.sv -----
`default_nettype none

package rep_pkg;

    localparam int MAX_LABELS = 1024;
    localparam int MAX_DIM    = 1024;
    localparam int COORD_W    = 10;
    localparam int ADDR_W     = $clog2(MAX_LABELS);
    localparam int NUM_DIRS   = 4;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [ADDR_W-1:0]  t_addr;

    typedef enum logic [1:0] {
        OP_PIXEL = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_UP    = 2'd3
    } t_dir;

    typedef enum logic {
        ST_SWEEP = 1'b0,
        ST_RUN   = 1'b1
    } t_state;

    typedef struct packed {
        t_coord second_end;
        t_coord first_end;
        t_coord coord;
    } t_edge;

    typedef struct packed {
        logic                       seen;
        t_edge [NUM_DIRS-1:0]       edges;
    } t_entry;

    typedef struct packed {
        logic   rd_en;
        t_addr  rd_addr;
        logic   wr_en;
        t_addr  wr_addr;
        t_entry wr_data;
    } t_mem_req;

    typedef struct packed {
        t_coord second_end;
        t_coord first_end;
        t_coord edge_coord;
        logic   label_seen;
    } t_result;

    function automatic t_coord f_min(t_coord a, t_coord b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_coord f_max(t_coord a, t_coord b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_edge f_set_edge(t_coord c, t_coord e);
        t_edge x;
        x.coord      = c;
        x.first_end  = e;
        x.second_end = e;
        return x;
    endfunction

    function automatic t_entry f_add_pixel(t_entry e, t_coord r, t_coord c);
        t_entry n;
        n = e;
        n.seen = 1'b1;
        if (!e.seen) begin
            n.edges[DIR_RIGHT] = f_set_edge(c, r);
            n.edges[DIR_DOWN]  = f_set_edge(r, c);
            n.edges[DIR_LEFT]  = f_set_edge(c, r);
            n.edges[DIR_UP]    = f_set_edge(r, c);
        end else begin
            if (c > e.edges[DIR_RIGHT].coord) begin
                n.edges[DIR_RIGHT] = f_set_edge(c, r);
            end else if (c == e.edges[DIR_RIGHT].coord) begin
                n.edges[DIR_RIGHT].first_end  = f_min(e.edges[DIR_RIGHT].first_end, r);
                n.edges[DIR_RIGHT].second_end = f_max(e.edges[DIR_RIGHT].second_end, r);
            end
            if (r > e.edges[DIR_DOWN].coord) begin
                n.edges[DIR_DOWN] = f_set_edge(r, c);
            end else if (r == e.edges[DIR_DOWN].coord) begin
                n.edges[DIR_DOWN].first_end  = f_max(e.edges[DIR_DOWN].first_end, c);
                n.edges[DIR_DOWN].second_end = f_min(e.edges[DIR_DOWN].second_end, c);
            end
            if (c < e.edges[DIR_LEFT].coord) begin
                n.edges[DIR_LEFT] = f_set_edge(c, r);
            end else if (c == e.edges[DIR_LEFT].coord) begin
                n.edges[DIR_LEFT].first_end  = f_max(e.edges[DIR_LEFT].first_end, r);
                n.edges[DIR_LEFT].second_end = f_min(e.edges[DIR_LEFT].second_end, r);
            end
            if (r < e.edges[DIR_UP].coord) begin
                n.edges[DIR_UP] = f_set_edge(r, c);
            end else if (r == e.edges[DIR_UP].coord) begin
                n.edges[DIR_UP].first_end  = f_min(e.edges[DIR_UP].first_end, c);
                n.edges[DIR_UP].second_end = f_max(e.edges[DIR_UP].second_end, c);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/rep_store.sv -----
`default_nettype none

module rep_store (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire rep_pkg::t_mem_req i_req,
    input  wire               i_flush,
    output rep_pkg::t_entry   o_rd_data
);
    import rep_pkg::*;

    t_entry r_mem [MAX_LABELS];
    t_entry r_q;
    t_addr  r_rd_addr;
    logic   r_fwd_valid;
    t_addr  r_fwd_addr;
    t_entry r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_q       <= r_mem[i_req.rd_addr];
            r_rd_addr <= i_req.rd_addr;
        end
    end

    // last write is bypassed so a read issued in the same cycle sees it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_fwd_valid <= 1'b0;
        end else if (i_req.wr_en) begin
            r_fwd_valid <= 1'b1;
        end
        if (i_req.wr_en) begin
            r_fwd_addr <= i_req.wr_addr;
            r_fwd_data <= i_req.wr_data;
        end
    end

    assign o_rd_data = (r_fwd_valid && r_fwd_addr == r_rd_addr) ? r_fwd_data : r_q;

endmodule

`default_nettype wire

// ----- hdl/region_extreme_points.sv -----
// Per-label region extreme points.
// Input stream (s_axis): one request per transfer; tuser carries the opcode
// (pixel update, edge read, clear). Pixels of any label are folded into a
// 1024-entry table holding four extreme edges per label; black and white
// labels are skipped; the user must set them on the config port while idle,
// the block does not enforce it. Output stream (m_axis): one result per edge
// read, nothing for other requests, via the stage-1 and result registers.
// Throughput: one request per cycle unless stalled or sweeping; the table is
// read as a request is accepted and written back in the next cycle, with the
// previous write bypassed to the pending read. Reset and clear: the table's
// seen bits are wiped by a sweep over all 1024 entries, one entry per cycle,
// during which s_axis_tready is low. Config writes are taken throughout.
// Stall: the result register holds while m_axis_tready is low; requests that
// give no result keep flowing, a second read waits until the result is taken.
`default_nettype none

module region_extreme_points (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // row[9:0], col[19:10], label[29:20], direction[31:30]
    input  wire  [31:0] i_s_axis_tdata,
    // opcode[1:0]
    input  wire  [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // label_seen[0], edge_coord[10:1], first_end[20:11], second_end[30:21], zero[31]
    output logic [31:0] o_m_axis_tdata,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [9:0]  i_cfg_wdata
);
    import rep_pkg::*;

    localparam logic CFG_BLACK = 1'b0;
    localparam logic CFG_WHITE = 1'b1;

    t_state   r_state, n_state;
    t_addr    r_sweep_cnt;
    logic     sweep_active;
    logic     sweep_last;

    t_coord   r_black, r_white;

    logic     r_s1_valid;
    t_op      r_s1_op;
    t_coord   r_s1_row, r_s1_col, r_s1_label;
    t_dir     r_s1_dir;

    logic     r_out_valid;
    t_result  r_out;

    logic     in_acc;
    logic     s1_adv;
    logic     s1_ok;
    t_entry   rd_entry;
    t_entry   upd_entry;
    t_mem_req mem_req;
    t_result  res;

    assign sweep_last = (r_sweep_cnt == t_addr'(MAX_LABELS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_SWEEP: if (sweep_last) n_state = ST_RUN;
            ST_RUN: begin
                if (in_acc && t_op'(i_s_axis_tuser) == OP_CLEAR) n_state = ST_SWEEP;
            end
            default: n_state = ST_SWEEP;
        endcase
    end

    always_comb begin
        case (r_state)
            ST_SWEEP: sweep_active = 1'b1;
            default:  sweep_active = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_sweep_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (sweep_active) begin
                r_sweep_cnt <= sweep_last ? '0 : r_sweep_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black <= '0;
            r_white <= t_coord'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BLACK: r_black <= i_cfg_wdata;
                CFG_WHITE: r_white <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s1_adv = !(r_s1_op == OP_READ) || !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !sweep_active && (!r_s1_valid || s1_adv);
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= (t_op'(i_s_axis_tuser) == OP_PIXEL)
                       || (t_op'(i_s_axis_tuser) == OP_READ);
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
        if (in_acc) begin
            r_s1_op    <= t_op'(i_s_axis_tuser);
            r_s1_row   <= i_s_axis_tdata[9:0];
            r_s1_col   <= i_s_axis_tdata[19:10];
            r_s1_label <= i_s_axis_tdata[29:20];
            r_s1_dir   <= t_dir'(i_s_axis_tdata[31:30]);
        end
    end

    assign s1_ok = (32'(r_s1_label) < MAX_LABELS) && (32'(r_s1_row) < MAX_DIM)
                && (32'(r_s1_col) < MAX_DIM)
                && (r_s1_label != r_black) && (r_s1_label != r_white);

    assign upd_entry = f_add_pixel(rd_entry, r_s1_row, r_s1_col);

    always_comb begin
        mem_req.rd_en   = in_acc;
        mem_req.rd_addr = t_addr'(i_s_axis_tdata[29:20]);
        if (sweep_active) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = r_sweep_cnt;
            mem_req.wr_data = '0;
        end else begin
            mem_req.wr_en   = r_s1_valid && r_s1_op == OP_PIXEL && s1_ok;
            mem_req.wr_addr = t_addr'(r_s1_label);
            mem_req.wr_data = upd_entry;
        end
    end

    rep_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .i_flush   (sweep_active),
        .o_rd_data (rd_entry)
    );

    always_comb begin
        res = '0;
        if ((32'(r_s1_label) < MAX_LABELS) && rd_entry.seen) begin
            res.label_seen = 1'b1;
            res.edge_coord = rd_entry.edges[r_s1_dir].coord;
            res.first_end  = rd_entry.edges[r_s1_dir].first_end;
            res.second_end = rd_entry.edges[r_s1_dir].second_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s1_valid && r_s1_op == OP_READ && s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (r_s1_valid && r_s1_op == OP_READ && s1_adv) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out};

endmodule

`default_nettype wire

// ----- hdl/rep_checker.sv -----
`default_nettype none

module rep_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_axis_tvalid,
    input wire        o_s_axis_tready,
    input wire [1:0]  i_s_axis_tuser,
    input wire        o_m_axis_tvalid,
    input wire        i_m_axis_tready,
    input wire [31:0] o_m_axis_tdata
);
    import rep_pkg::*;

    // result held under backpressure
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // table sweep follows reset
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("request taken during reset sweep");

    // clear starts a sweep
    a_clear_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == OP_CLEAR
        |=> !o_s_axis_tready)
        else $error("request taken right after clear");

    // unseen label reads as all zero
    a_unseen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[0] |-> o_m_axis_tdata[31:1] == '0)
        else $error("unseen label with nonzero edge");

endmodule

bind region_extreme_points rep_checker u_rep_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
